>>> hw/rtl/sdsl_pkg.sv
// sdsl_pkg: shared types, constants and codes of the six channel duty slew limiter
// no dependencies; used by sdsl_lane, sdsl_merge and six_channel_duty_slew_limiter
package sdsl_pkg;

  localparam int NumCh     = 6;
  localparam int FracBits  = 14;
  localparam int DutyW     = 16;
  localparam int GainW     = 16;
  localparam int GainShift = 16;
  localparam int StepCfgW  = 15;
  localparam int MagW      = 15;
  localparam int IdxW      = 3;
  localparam int CfgW      = 16;
  localparam int CfgIdxW   = 2;

  localparam int DeltaW = DutyW + 1;
  localparam int ProdW  = DeltaW + GainW + 1;
  localparam int StepW  = ProdW - GainShift;

  localparam logic [31:0] DutyOne = 32'(1) << FracBits;
  localparam logic [31:0] MagMax  = (32'(1) << MagW) - 32'(1);

  typedef enum logic {
    ActWrite = 1'b0,
    ActTick  = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegGain     = 2'd0,
    RegMaxStep  = 2'd1,
    RegDeadBand = 2'd2,
    RegLockMask = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ModeCcw   = 2'b01,
    ModeCw    = 2'b10,
    ModeBrake = 2'b11
  } mode_e;

  typedef struct packed {
    logic                    action;
    logic [IdxW-1:0]         motor_index;
    logic signed [DutyW-1:0] target_duty;
    logic                    from_host;
  } in_item_t;

  typedef struct packed {
    logic [MagW-1:0]    duty_mag_0;
    logic [MagW-1:0]    duty_mag_1;
    logic [MagW-1:0]    duty_mag_2;
    logic [MagW-1:0]    duty_mag_3;
    logic [MagW-1:0]    duty_mag_4;
    logic [MagW-1:0]    duty_mag_5;
    logic [2*NumCh-1:0] drive_modes;
    logic               activity_led;
  } out_item_t;

  typedef struct packed {
    logic wr;
    logic tick;
  } lane_ctrl_t;

  typedef struct packed {
    logic [GainW-1:0]    gain;
    logic [StepCfgW-1:0] max_step;
    logic [StepCfgW-1:0] dead_band;
  } lane_cfg_t;

  typedef struct packed {
    logic [MagW-1:0] mag;
    mode_e           mode;
    logic            active;
  } lane_res_t;

endpackage

>>> hw/rtl/six_channel_duty_slew_limiter.sv
// six_channel_duty_slew_limiter: top level, config registers, write decode, six lanes, merge
// depends on sdsl_pkg, sdsl_lane, sdsl_merge
//
// Input channel (in_valid_i, in_stall_o, in_data_i) carries write and tick items.
// A write item sets one channel's target duty and gives no result; it is dropped
// for a channel index of six or more, or for a locked channel when from_host is 0.
// A tick item steps all six actual duties at once in six lanes, one multiply and
// clamp each, and gives one result item on (out_valid_o, out_stall_i, out_data_o).
// An accepted tick sets stage one (s1_q), which loads the result into the output register.
// Throughput: one item per cycle when not stalled, ticks and writes mixed in any order.
// The output register holds one finished result while the actual duties already
// hold the next tick's update; with both held by a stall on the output, in_stall_o
// rises in the same cycle and drops as soon as the receiver takes the result.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (gain, max_step,
// dead_band, input_lock_mask) at the clock edge; write only while the block is idle.
// Reset clears all target and actual duties, empties the pipeline and loads
// gain 0.2, max_step 0.5, dead_band 16 and an open lock mask; no clearing pass.
module six_channel_duty_slew_limiter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sdsl_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sdsl_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [sdsl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sdsl_pkg::CfgW-1:0]       cfg_wdata_i
);

  logic [sdsl_pkg::GainW-1:0]    gain_q;
  logic [sdsl_pkg::StepCfgW-1:0] max_step_q, dead_band_q;
  logic [sdsl_pkg::NumCh-1:0]    lock_q;
  logic                          s1_q, s1_d, s1_adv, in_acc, tick_acc, wr_acc;
  sdsl_pkg::lane_cfg_t           lane_cfg;
  sdsl_pkg::lane_ctrl_t          lane_ctrl [sdsl_pkg::NumCh];
  sdsl_pkg::lane_res_t           lane_res  [sdsl_pkg::NumCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= 16'd13107;
      max_step_q  <= 15'd8192;
      dead_band_q <= 15'd16;
      lock_q      <= '0;
    end else if (cfg_we_i) begin
      case (sdsl_pkg::reg_idx_e'(cfg_idx_i))
        sdsl_pkg::RegGain:     gain_q      <= cfg_wdata_i[sdsl_pkg::GainW-1:0];
        sdsl_pkg::RegMaxStep:  max_step_q  <= cfg_wdata_i[sdsl_pkg::StepCfgW-1:0];
        sdsl_pkg::RegDeadBand: dead_band_q <= cfg_wdata_i[sdsl_pkg::StepCfgW-1:0];
        sdsl_pkg::RegLockMask: lock_q      <= cfg_wdata_i[sdsl_pkg::NumCh-1:0];
        default: ;
      endcase
    end
  end

  assign lane_cfg.gain      = gain_q;
  assign lane_cfg.max_step  = max_step_q;
  assign lane_cfg.dead_band = dead_band_q;

  // stage one holds a ticked result until the output register frees up
  assign s1_adv     = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (in_data_i.action == sdsl_pkg::ActTick);
  assign wr_acc     = in_acc && (in_data_i.action == sdsl_pkg::ActWrite);

  always_comb begin
    if (tick_acc) begin
      s1_d = 1'b1;
    end else if (s1_adv) begin
      s1_d = 1'b0;
    end else begin
      s1_d = s1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else begin
      s1_q <= s1_d;
    end
  end

  for (genvar c = 0; c < sdsl_pkg::NumCh; c++) begin : g_lane
    assign lane_ctrl[c].tick = tick_acc;
    assign lane_ctrl[c].wr   = wr_acc
                             && (in_data_i.motor_index == sdsl_pkg::IdxW'(c))
                             && (!lock_q[c] || in_data_i.from_host);

    sdsl_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl[c]),
      .tgt_i  (in_data_i.target_duty),
      .cfg_i  (lane_cfg),
      .res_o  (lane_res[c])
    );
  end

  sdsl_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_q && s1_adv),
    .out_stall_i (out_stall_i),
    .res_i       (lane_res),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_tick_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> s1_q)
    else $error("accepted tick did not reach stage one");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_q && out_valid_o))
    else $error("input stalled with nothing in flight");

  a_brake_all_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (&out_data_o.drive_modes)) |-> !out_data_o.activity_led)
    else $error("activity raised while every channel brakes");

  a_mag_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.duty_mag_0) <= sdsl_pkg::DutyOne
                  && 32'(out_data_o.duty_mag_1) <= sdsl_pkg::DutyOne
                  && 32'(out_data_o.duty_mag_2) <= sdsl_pkg::DutyOne
                  && 32'(out_data_o.duty_mag_3) <= sdsl_pkg::DutyOne
                  && 32'(out_data_o.duty_mag_4) <= sdsl_pkg::DutyOne
                  && 32'(out_data_o.duty_mag_5) <= sdsl_pkg::DutyOne))
    else $error("duty magnitude above full scale");
`endif

endmodule

>>> hw/rtl/sdsl_lane.sv
// sdsl_lane: one channel, target and actual duty registers, gain multiply and slew clamp
// reports magnitude, drive mode and activity of the stored actual duty; uses sdsl_pkg
module sdsl_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sdsl_pkg::lane_ctrl_t             ctrl_i,
  input  logic signed [sdsl_pkg::DutyW-1:0] tgt_i,
  input  sdsl_pkg::lane_cfg_t              cfg_i,
  output sdsl_pkg::lane_res_t              res_o
);

  logic signed [sdsl_pkg::DutyW-1:0]  tgt_q, act_q, act_d;
  logic signed [sdsl_pkg::DeltaW-1:0] delta, act_ext, db_ext;
  logic signed [sdsl_pkg::ProdW-1:0]  prod;
  logic signed [sdsl_pkg::StepW-1:0]  step_raw, step_cl, lim, sum;
  logic [sdsl_pkg::DeltaW-1:0]        abs_v;
  logic [31:0]                        mag_w;

  // floored gain step, clamped to +/- max_step, added to the duty with saturation
  always_comb begin
    delta    = {tgt_q[sdsl_pkg::DutyW-1], tgt_q} - {act_q[sdsl_pkg::DutyW-1], act_q};
    prod     = delta * $signed({1'b0, cfg_i.gain});
    step_raw = prod[sdsl_pkg::ProdW-1:sdsl_pkg::GainShift];
    lim      = $signed({{(sdsl_pkg::StepW-sdsl_pkg::StepCfgW){1'b0}}, cfg_i.max_step});
    if (step_raw > lim) begin
      step_cl = lim;
    end else if (step_raw < -lim) begin
      step_cl = -lim;
    end else begin
      step_cl = step_raw;
    end
    sum = {{(sdsl_pkg::StepW-sdsl_pkg::DutyW){act_q[sdsl_pkg::DutyW-1]}}, act_q} + step_cl;
    if (sum > $signed(sdsl_pkg::StepW'(32767))) begin
      act_d = 16'sh7fff;
    end else if (sum < -$signed(sdsl_pkg::StepW'(32768))) begin
      act_d = 16'sh8000;
    end else begin
      act_d = sum[sdsl_pkg::DutyW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
      act_q <= '0;
    end else begin
      if (ctrl_i.wr) begin
        tgt_q <= tgt_i;
      end
      if (ctrl_i.tick) begin
        act_q <= act_d;
      end
    end
  end

  // magnitude, mode and activity of the stored duty
  always_comb begin
    act_ext = {act_q[sdsl_pkg::DutyW-1], act_q};
    db_ext  = $signed({2'b00, cfg_i.dead_band});
    abs_v   = act_q[sdsl_pkg::DutyW-1] ? 17'(-act_ext) : 17'(act_ext);
    mag_w   = {15'd0, abs_v};
    if (mag_w > sdsl_pkg::DutyOne) begin
      mag_w = sdsl_pkg::DutyOne;
    end
    if (mag_w > sdsl_pkg::MagMax) begin
      mag_w = sdsl_pkg::MagMax;
    end
    res_o.mag = mag_w[sdsl_pkg::MagW-1:0];
    if (act_ext < db_ext && act_ext > -db_ext) begin
      res_o.mode = sdsl_pkg::ModeBrake;
    end else if (act_ext > 17'sd0) begin
      res_o.mode = sdsl_pkg::ModeCw;
    end else begin
      res_o.mode = sdsl_pkg::ModeCcw;
    end
    res_o.active = (act_ext > db_ext) || (act_ext < -db_ext);
  end

endmodule

>>> hw/rtl/sdsl_merge.sv
// sdsl_merge: packs the lane results into one result item and holds it in the output register
// uses sdsl_pkg
module sdsl_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                out_stall_i,
  input  sdsl_pkg::lane_res_t res_i [sdsl_pkg::NumCh],
  output logic                out_valid_o,
  output sdsl_pkg::out_item_t out_data_o
);

  sdsl_pkg::out_item_t out_d, out_q;
  logic                valid_q;
  logic                any_active;
  logic [2*sdsl_pkg::NumCh-1:0] modes;

  always_comb begin
    any_active = 1'b0;
    modes      = '0;
    for (int c = 0; c < sdsl_pkg::NumCh; c++) begin
      any_active       = any_active | res_i[c].active;
      modes[2*c +: 2]  = res_i[c].mode;
    end
    out_d.duty_mag_0   = res_i[0].mag;
    out_d.duty_mag_1   = res_i[1].mag;
    out_d.duty_mag_2   = res_i[2].mag;
    out_d.duty_mag_3   = res_i[3].mag;
    out_d.duty_mag_4   = res_i[4].mag;
    out_d.duty_mag_5   = res_i[5].mag;
    out_d.drive_modes  = modes;
    out_d.activity_led = any_active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

endmodule

>>> test/sdsl_checker.sv
// sdsl_checker: watches the item, result and register ports of the duty slew limiter,
// predicts every tick result from its own copy of targets, actuals and registers
// depends on sdsl_pkg; instantiated beside the block by testbench
module sdsl_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  sdsl_pkg::in_item_t           in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  sdsl_pkg::out_item_t          out_data_i,
  input  logic                         cfg_we_i,
  input  logic [sdsl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sdsl_pkg::CfgW-1:0]    cfg_wdata_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  import sdsl_pkg::*;

  logic signed [DutyW-1:0] target_duty [NumCh];
  logic signed [DutyW-1:0] actual_duty [NumCh];
  logic [GainW-1:0]        gain_q;
  logic [StepCfgW-1:0]     max_step_q;
  logic [StepCfgW-1:0]     dead_band_q;
  logic [NumCh-1:0]        lock_mask_q;

  out_item_t predicted_q [$];

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  task automatic report(string what, longint want, longint got);
    $display("mismatch %s: expected %0d, got %0d", what, want, got);
    fail_count_o++;
  endtask

  // advance all actual duties by one tick and build the result it gives
  function automatic out_item_t step_duties();
    out_item_t          res;
    logic [MagW-1:0]    mags [NumCh];
    logic [2*NumCh-1:0] modes;
    logic               active;
    longint             delta, step, lim, db, nxt, mag;
    modes  = '0;
    active = 1'b0;
    lim    = longint'(max_step_q);
    db     = longint'(dead_band_q);
    for (int c = 0; c < NumCh; c++) begin
      delta = longint'(target_duty[c]) - longint'(actual_duty[c]);
      step  = (delta * longint'(gain_q)) >>> GainShift;
      if (step > lim) step = lim;
      else if (step < -lim) step = -lim;
      nxt = longint'(actual_duty[c]) + step;
      if (nxt > 32767) nxt = 32767;
      else if (nxt < -32768) nxt = -32768;
      actual_duty[c] = DutyW'(nxt);
      mag = (nxt < 0) ? -nxt : nxt;
      if (mag > longint'(DutyOne)) mag = longint'(DutyOne);
      if (mag > longint'(MagMax)) mag = longint'(MagMax);
      mags[c] = MagW'(mag);
      if (nxt < db && nxt > -db) modes[2*c +: 2] = ModeBrake;
      else if (nxt > 0) modes[2*c +: 2] = ModeCw;
      else modes[2*c +: 2] = ModeCcw;
      if (nxt > db || nxt < -db) active = 1'b1;
    end
    res.duty_mag_0   = mags[0];
    res.duty_mag_1   = mags[1];
    res.duty_mag_2   = mags[2];
    res.duty_mag_3   = mags[3];
    res.duty_mag_4   = mags[4];
    res.duty_mag_5   = mags[5];
    res.drive_modes  = modes;
    res.activity_led = active;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int c = 0; c < NumCh; c++) begin
        target_duty[c] = '0;
        actual_duty[c] = '0;
      end
      gain_q      = 16'd13107;
      max_step_q  = 15'd8192;
      dead_band_q = 15'd16;
      lock_mask_q = '0;
      predicted_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_q.size() == 0) begin
          report("unexpected result item", 0, 1);
        end else begin
          want = predicted_q.pop_front();
          if (out_data_i.duty_mag_0 !== want.duty_mag_0)
            report("duty_mag_0", want.duty_mag_0, out_data_i.duty_mag_0);
          if (out_data_i.duty_mag_1 !== want.duty_mag_1)
            report("duty_mag_1", want.duty_mag_1, out_data_i.duty_mag_1);
          if (out_data_i.duty_mag_2 !== want.duty_mag_2)
            report("duty_mag_2", want.duty_mag_2, out_data_i.duty_mag_2);
          if (out_data_i.duty_mag_3 !== want.duty_mag_3)
            report("duty_mag_3", want.duty_mag_3, out_data_i.duty_mag_3);
          if (out_data_i.duty_mag_4 !== want.duty_mag_4)
            report("duty_mag_4", want.duty_mag_4, out_data_i.duty_mag_4);
          if (out_data_i.duty_mag_5 !== want.duty_mag_5)
            report("duty_mag_5", want.duty_mag_5, out_data_i.duty_mag_5);
          if (out_data_i.drive_modes !== want.drive_modes)
            report("drive_modes", want.drive_modes, out_data_i.drive_modes);
          if (out_data_i.activity_led !== want.activity_led)
            report("activity_led", want.activity_led, out_data_i.activity_led);
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegGain:     gain_q      = cfg_wdata_i[GainW-1:0];
          RegMaxStep:  max_step_q  = cfg_wdata_i[StepCfgW-1:0];
          RegDeadBand: dead_band_q = cfg_wdata_i[StepCfgW-1:0];
          RegLockMask: lock_mask_q = cfg_wdata_i[NumCh-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.action == ActTick) begin
          predicted_q.push_back(step_duties());
        end else if (in_data_i.motor_index < NumCh) begin
          if (!lock_mask_q[in_data_i.motor_index] || in_data_i.from_host)
            target_duty[in_data_i.motor_index] = in_data_i.target_duty;
        end
      end
    end
    pending_o = predicted_q.size();
  end

endmodule

>>> test/testbench.sv
// testbench: drives write and tick items, register settings and output stalls into
// six_channel_duty_slew_limiter; depends on sdsl_pkg, the block and sdsl_checker
module testbench;
  import sdsl_pkg::*;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  in_item_t            in_data     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  out_item_t           out_data;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx     = '0;
  logic [CfgW-1:0]     cfg_wdata   = '0;
  int                  pending;
  int                  fails;
  bit                  calm        = 1'b0;
  bit                  hold_req    = 1'b0;

  localparam int HoldCycles  = 60;
  localparam int PhaseItems  = 190;
  localparam int RandPhases  = 8;

  six_channel_duty_slew_limiter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  sdsl_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [DutyW-1:0] rand_duty();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd16384;
      3: return -16'sd16384;
      4: return DutyW'($urandom_range(0, 64)) - 16'sd32;
      default: return DutyW'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.action      = ($urandom_range(0, 99) < 40) ? ActTick : ActWrite;
    it.motor_index = ($urandom_range(0, 9) == 0) ? IdxW'($urandom_range(6, 7))
                                                 : IdxW'($urandom_range(0, 5));
    it.target_duty = rand_duty();
    it.from_host   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // output side: random stalls, a long hold-off on request
  initial begin
    int r;
    int n;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 6);
        end else if (r < 93) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(10, 30);
        end
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(in_item_t it);
    int g;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wr(int idx, int duty, bit host);
    in_item_t it;
    it.action      = ActWrite;
    it.motor_index = IdxW'(idx);
    it.target_duty = DutyW'(duty);
    it.from_host   = host;
    send_item(it);
  endtask

  task automatic tk();
    in_item_t it;
    it             = rand_item();
    it.action      = ActTick;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [CfgW-1:0] g, logic [CfgW-1:0] ms,
                              logic [CfgW-1:0] db, logic [CfgW-1:0] lk);
    cfg_we    <= 1'b1;
    cfg_idx   <= RegGain;
    cfg_wdata <= g;
    @(posedge clk_i);
    cfg_idx   <= RegMaxStep;
    cfg_wdata <= ms;
    @(posedge clk_i);
    cfg_idx   <= RegDeadBand;
    cfg_wdata <= db;
    @(posedge clk_i);
    cfg_idx   <= RegLockMask;
    cfg_wdata <= lk;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic phase_regs(int p);
    case (p)
      0: program_regs(16'd13107, 16'd8192, 16'd16, 16'd0);
      1: program_regs(16'hffff, 16'd32767, 16'd0, 16'd63);
      2: program_regs(16'd0, 16'd0, 16'd16384, 16'd0);
      3: program_regs(16'd1, 16'd1, 16'd1, 16'h002a);
      5: program_regs(16'd32768, 16'd16384, 16'd100, 16'd21);
      7: program_regs(16'hffff, 16'd300, 16'd16384, 16'hffff);
      default: program_regs(CfgW'($urandom), CfgW'($urandom),
                            CfgW'($urandom), CfgW'($urandom));
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full gain, step limit equal to band: first steps land exactly on the band edge
    program_regs(16'hffff, 16'd16, 16'd16, 16'd0);
    wr(0, 1000, 1'b0);
    tk();
    wr(1, -1000, 1'b1);
    tk();
    drain();
    // all channels locked: only the host write gets through
    program_regs(16'hffff, 16'd16, 16'd16, 16'd63);
    wr(2, 5000, 1'b0);
    wr(3, -5000, 1'b1);
    tk();
    drain();
    // zero band: idle channels at zero report ccw
    program_regs(16'd13107, 16'd8192, 16'd0, 16'd0);
    tk();
    wr(0, 32767, 1'b0);
    wr(1, -32768, 1'b0);
    wr(2, 16384, 1'b1);
    wr(4, -16384, 1'b0);
    wr(5, -1, 1'b0);
    wr(6, 1234, 1'b1);
    wr(7, -1, 1'b0);
    tk();
    tk();
    tk();
    tk();
    drain();

    for (int p = 0; p < RandPhases; p++) begin
      phase_regs(p);
      calm = (p == 5);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n == PhaseItems / 2) begin
          if (p == 3 || p == 6) hold_req = 1'b1;
          if (p == 2 || p == 4) drain();
        end
        send_item(rand_item());
      end
      drain();
      calm = 1'b0;
    end

    repeat (10) @(posedge clk_i);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sdsl_pkg.sv
hw/rtl/sdsl_lane.sv
hw/rtl/sdsl_merge.sv
hw/rtl/six_channel_duty_slew_limiter.sv
test/sdsl_checker.sv
test/testbench.sv
